// File: src/salts_pkg.sv
`default_nettype none
package salts_pkg;
  // configuration register indexes
  localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
  localparam logic [1:0] CFG_WAYS       = 2'd1;
  localparam logic [1:0] CFG_SETS       = 2'd2;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_CLEAR = 3'd6;
endpackage
`default_nettype wire

// File: src/set_assoc_lru_tag_store_core.sv
`default_nettype none
// Set-associative tag store with least-recently-used replacement.
// Request channel: start_i with address_i, accepted when start_i is high and busy_o
// is low. Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 block size,
// 1 ways in use, 2 sets in use) and cfg_data_i; writes are taken at any time but
// belong between requests.
// Each request yields one result on hit_o, set_index_o, hit_total_o and miss_total_o,
// shown for exactly one cycle with done_o high; the receiver cannot stall it.
// A request runs the shared restoring divide/subtract unit first for the block
// number, then again for the modulo by the set count (the same unit), then passes
// through a read state, a scan state that steps through the ways in use and an
// update state. busy_o drops with done_o, so a new request is taken only once the
// last result is out.
// After reset the age/valid memory is cleared one set per cycle, and busy_o stays
// high until it is done. Counters and configuration reset at once.
module set_assoc_lru_tag_store_core #(
  parameter int unsigned MAX_SETS  = 64,
  parameter int unsigned MAX_WAYS  = 8,
  parameter int unsigned ADDR_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] address_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             done_o,
  output logic             hit_o,
  output logic [5:0]       set_index_o,
  output logic [31:0]      hit_total_o,
  output logic [31:0]      miss_total_o
);
  localparam int unsigned SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned AW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  // counter covers both the divide steps and the clearing pass
  localparam int unsigned CW = (MAX_SETS > ADDR_BITS + 1) ? $clog2(MAX_SETS) :
                                                            $clog2(ADDR_BITS + 1);
  localparam logic [AW-1:0] AGE_MAX = AW'(MAX_WAYS - 1);
  localparam int unsigned RW = 17; // remainder width: divisor up to 16 bits

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] age;
  } meta_t;

  // per-set row: valid and age for every way; tags in a separate memory
  logic [MAX_WAYS*(AW+1)-1:0] meta_mem [MAX_SETS];
  logic [ADDR_BITS-1:0]       tag_mem  [MAX_SETS*MAX_WAYS];

  logic [2:0]           state_q, state_d;
  logic [15:0]          bsize_q;
  logic [3:0]           ways_q;
  logic [6:0]           sets_q;
  logic [CW-1:0]        cnt_q;
  logic [ADDR_BITS-1:0] quo_q;       // dividend shifted out / quotient in
  logic [ADDR_BITS-1:0] blk_q;
  logic [RW-1:0]        rem_q;
  logic [15:0]          dsr_q;
  logic [SW-1:0]        set_q;
  logic [WW:0]          way_q;
  logic [WW:0]          nw_q;
  logic [MAX_WAYS*(AW+1)-1:0] row_q;
  logic [ADDR_BITS-1:0] tag_rd_q;
  logic                 found_q, vic_ok_q, free_ok_q;
  logic [WW-1:0]        found_w_q, vic_w_q, free_w_q;
  logic [AW-1:0]        vic_age_q;
  logic [31:0]          hits_q, misses_q;

  // shared restoring division step
  logic [RW-1:0] trial;
  logic [RW-1:0] sub;
  logic          ge;
  always_comb begin
    trial = {rem_q[RW-2:0], quo_q[ADDR_BITS-1]};
    sub   = trial - RW'(dsr_q);
    ge    = trial >= RW'(dsr_q);
  end

  assign busy_o      = state_q != salts_pkg::ST_IDLE;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q <= 16'd64;
      ways_q  <= 4'd8;
      sets_q  <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        salts_pkg::CFG_BLOCK_SIZE: bsize_q <= cfg_data_i;
        salts_pkg::CFG_WAYS:       ways_q  <= cfg_data_i[3:0];
        salts_pkg::CFG_SETS:       sets_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // current way's metadata and the updated LRU row
  meta_t cur;
  meta_t hit_m;
  logic [WW-1:0] wi;
  logic [AW-1:0] hit_age;
  logic [WW-1:0] slot;
  logic [AW-1:0] lim_age;
  logic          use_lim;
  logic [MAX_WAYS*(AW+1)-1:0] row_new;
  always_comb begin
    wi  = way_q[WW-1:0];
    cur = meta_t'(row_q[wi*(AW+1) +: (AW+1)]);
    hit_m   = meta_t'(row_q[found_w_q*(AW+1) +: (AW+1)]);
    hit_age = hit_m.age;
    slot    = found_q ? found_w_q : (free_ok_q ? free_w_q : vic_w_q);
    use_lim = found_q || !free_ok_q;
    lim_age = found_q ? hit_age : vic_age_q;
    row_new = row_q;
    for (int w = 0; w < MAX_WAYS; w++) begin
      meta_t m;
      m = meta_t'(row_q[w*(AW+1) +: (AW+1)]);
      if (w < int'(nw_q) && m.valid && w != int'(slot) &&
          (!use_lim || m.age < lim_age) && m.age != AGE_MAX)
        m.age = m.age + AW'(1);
      if (w == int'(slot)) begin
        m.valid = 1'b1;
        m.age   = '0;
      end
      row_new[w*(AW+1) +: (AW+1)] = m;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (state_q == salts_pkg::ST_CLEAR)
      meta_mem[cnt_q[SW-1:0]] <= '0;
    else if (state_q == salts_pkg::ST_UPD)
      meta_mem[set_q] <= row_new;
    if (state_q == salts_pkg::ST_UPD && !found_q)
      tag_mem[{set_q, slot}] <= blk_q;
    if (state_q == salts_pkg::ST_READ)
      row_q <= meta_mem[set_q];
    if (state_q == salts_pkg::ST_READ || state_q == salts_pkg::ST_SCAN)
      tag_rd_q <= tag_mem[{set_q, (state_q == salts_pkg::ST_READ) ? WW'(0) :
                           WW'(way_q + 1'b1)}];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      salts_pkg::ST_CLEAR:
        if (cnt_q == CW'(MAX_SETS - 1)) state_d = salts_pkg::ST_IDLE;
      salts_pkg::ST_IDLE:
        if (start_i) state_d = salts_pkg::ST_DIV;
      salts_pkg::ST_DIV:
        if (cnt_q == CW'(1)) state_d = salts_pkg::ST_MOD;
      salts_pkg::ST_MOD:
        if (cnt_q == CW'(1)) state_d = salts_pkg::ST_READ;
      salts_pkg::ST_READ: state_d = salts_pkg::ST_SCAN;
      salts_pkg::ST_SCAN:
        if (way_q == nw_q - 1'b1) state_d = salts_pkg::ST_UPD;
      salts_pkg::ST_UPD: state_d = salts_pkg::ST_IDLE;
      default: state_d = salts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= salts_pkg::ST_CLEAR;
      cnt_q    <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      done_o   <= 1'b0;
      hit_o    <= 1'b0;
      set_index_o  <= '0;
      hit_total_o  <= '0;
      miss_total_o <= '0;
    end else begin
      state_q <= state_d;
      done_o  <= state_q == salts_pkg::ST_UPD;
      case (state_q)
        salts_pkg::ST_CLEAR: cnt_q <= cnt_q + 1'b1;
        salts_pkg::ST_IDLE:  cnt_q <= CW'(ADDR_BITS);
        salts_pkg::ST_DIV:   cnt_q <= (cnt_q == CW'(1)) ? CW'(ADDR_BITS) : cnt_q - 1'b1;
        salts_pkg::ST_MOD:   cnt_q <= cnt_q - 1'b1;
        salts_pkg::ST_UPD: begin
          hit_o       <= found_q;
          set_index_o <= 6'(set_q);
          if (found_q) begin
            if (hits_q != '1) hits_q <= hits_q + 1'b1;
            hit_total_o  <= (hits_q != '1) ? hits_q + 1'b1 : hits_q;
            miss_total_o <= misses_q;
          end else begin
            if (misses_q != '1) misses_q <= misses_q + 1'b1;
            miss_total_o <= (misses_q != '1) ? misses_q + 1'b1 : misses_q;
            hit_total_o  <= hits_q;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath: division, modulo and way scan
  always_ff @(posedge clk_i) begin
    case (state_q)
      salts_pkg::ST_IDLE: begin
        quo_q <= ADDR_BITS'(address_i);
        rem_q <= '0;
        dsr_q <= (bsize_q == '0) ? 16'd1 : bsize_q;
        nw_q  <= (ways_q == '0) ? (WW+1)'(1) :
                 (32'(ways_q) > MAX_WAYS) ? (WW+1)'(MAX_WAYS) : (WW+1)'(ways_q);
      end
      salts_pkg::ST_DIV: begin
        quo_q <= {quo_q[ADDR_BITS-2:0], ge};
        if (cnt_q == CW'(1)) begin
          blk_q <= {quo_q[ADDR_BITS-2:0], ge};
          rem_q <= '0;
          dsr_q <= (sets_q == '0) ? 16'd1 :
                   (32'(sets_q) > MAX_SETS) ? 16'(MAX_SETS) : 16'(sets_q);
        end else begin
          rem_q <= ge ? sub : trial;
        end
      end
      salts_pkg::ST_MOD: begin
        quo_q <= {quo_q[ADDR_BITS-2:0], 1'b0};
        rem_q <= ge ? sub : trial;
        if (cnt_q == CW'(1)) set_q <= ge ? SW'(sub) : SW'(trial);
        way_q     <= '0;
        found_q   <= 1'b0;
        vic_ok_q  <= 1'b0;
        free_ok_q <= 1'b0;
      end
      salts_pkg::ST_SCAN: begin
        way_q <= way_q + 1'b1;
        if (cur.valid) begin
          if (!found_q && tag_rd_q == blk_q) begin
            found_q   <= 1'b1;
            found_w_q <= wi;
          end
          if (!vic_ok_q || cur.age > vic_age_q) begin
            vic_ok_q  <= 1'b1;
            vic_w_q   <= wi;
            vic_age_q <= cur.age;
          end
        end else if (!free_ok_q) begin
          free_ok_q <= 1'b1;
          free_w_q  <= wi;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
